// ===== design/bds_pkg.sv =====
// Shared types, constants and channel arithmetic for the 2x2 box downsampler.
// No dependencies; imported by every module of the block.
package bds_pkg;

  // Field and register widths
  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int SUM_W   = 9;
  localparam int NUM_CH  = 4;
  localparam int PAIR_W  = NUM_CH * SUM_W;
  localparam int DIM_W   = 13;
  localparam int ROW_W   = 12;
  localparam int CFG_IDX_W = 1;

  // Size limits and register reset values
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam logic [DIM_W-1:0] MIN_DIM      = 13'd2;
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;

  // What the control decodes for the pixel at the input
  typedef struct packed {
    logic keep;       // neither in a dropped column nor a dropped row
    logic odd_col;    // right pixel of a horizontal pair
    logic odd_row;    // bottom row of a row pair
    logic row_end;    // last block of an output row
    logic frame_end;  // last block of the frame
  } step_t;

  // Four 9-bit channel sums of two pixels, channel c at bit 9*c
  function automatic logic [PAIR_W-1:0] pair_sums(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
    logic [PAIR_W-1:0] r;
    r = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      r[SUM_W*c +: SUM_W] = {1'b0, a[CH_W*c +: CH_W]} + {1'b0, b[CH_W*c +: CH_W]};
    end
    return r;
  endfunction

  // Floor mean of the four bytes of each channel
  function automatic logic [PIX_W-1:0] block_mean(input logic [PAIR_W-1:0] top,
                                                  input logic [PAIR_W-1:0] bot);
    logic [PIX_W-1:0] r;
    logic [SUM_W:0]   s;
    r = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      s = {1'b0, top[SUM_W*c +: SUM_W]} + {1'b0, bot[SUM_W*c +: SUM_W]};
      r[CH_W*c +: CH_W] = s[SUM_W:2];
    end
    return r;
  endfunction

endpackage

// ===== design/bds_ctrl.sv =====
// Size registers, source column/row counters and per-pixel decode.
// Depends on bds_pkg.
module bds_ctrl #(
  parameter int MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bds_pkg::DIM_W-1:0]      cfg_data,
  input  logic                           accept,
  output bds_pkg::step_t                 step,
  output logic [$clog2(MAX_WIDTH)-1:0]   col
);
  import bds_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > DIM_W) ? WW : DIM_W;

  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;
  logic [XW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [WW-1:0]    w;
  logic [DIM_W-1:0] h;
  logic [XW-1:0]    col_half;
  logic [ROW_W-1:0] row_half;
  logic             last_col;
  logic             last_row;
  logic             row_end;

  // Size registers; any write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RESET_WIDTH;
      src_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the sizes to the supported range
  always_comb begin
    if (src_width < MIN_DIM) begin
      w = WW'(2);
    end else if (CW'(src_width) > CW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(src_width);
    end
    if (src_height < MIN_DIM) begin
      h = MIN_DIM;
    end else if (src_height > DIM_W'(MAX_HEIGHT)) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = src_height;
    end
  end

  // Position decode
  always_comb begin
    col_half       = col_count >> 1;
    row_half       = row_count >> 1;
    last_col       = WW'(col_count) == w - WW'(1);
    last_row       = DIM_W'(row_count) == h - DIM_W'(1);
    row_end        = WW'(col_half) == (w >> 1) - WW'(1);
    step.keep      = !(w[0] && last_col) && !(h[0] && last_row);
    step.odd_col   = col_count[0];
    step.odd_row   = row_count[0];
    step.row_end   = row_end;
    step.frame_end = row_end && (DIM_W'(row_half) == (h >> 1) - DIM_W'(1));
  end

  assign col = col_count;

  // Raster counters
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + XW'(1);
      end
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WW'(col_count) < w) else $error("column count beyond source width");
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(row_count) < h) else $error("row count beyond source height");

endmodule

// ===== design/bds_line.sv =====
// Held left pixel, horizontal pair sums and the line store of even-row pair sums.
// Depends on bds_pkg.
module bds_line #(
  parameter int MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          accept,
  input  logic [bds_pkg::PIX_W-1:0]     in_pixel,
  input  bds_pkg::step_t                step,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col,
  output logic [bds_pkg::PAIR_W-1:0]    pair,
  output logic [bds_pkg::PAIR_W-1:0]    top_pair
);
  import bds_pkg::*;

  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [PIX_W-1:0]  held_pixel;
  logic [PAIR_W-1:0] mem [LINE_DEPTH];
  logic [XW-1:0]     col_half;
  logic [AW-1:0]     addr;

  assign col_half = col >> 1;
  assign addr     = AW'(col_half);
  assign pair     = pair_sums(held_pixel, in_pixel);

  // Left pixel of the current pair
  always_ff @(posedge clk) begin
    if (accept && step.keep && !step.odd_col) begin
      held_pixel <= in_pixel;
    end
  end

  // Even rows write their pair sums; odd rows read the ones above
  always_ff @(posedge clk) begin
    if (accept && step.keep && step.odd_col && !step.odd_row) begin
      mem[addr] <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_pair <= mem[addr];
    end
  end

endmodule

// ===== design/bds_out.sv =====
// Block stage (bottom pair sums and marks) and the output register.
// Depends on bds_pkg.
module bds_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bds_pkg::step_t              step,
  input  logic [bds_pkg::PAIR_W-1:0]  pair,
  input  logic [bds_pkg::PAIR_W-1:0]  top_pair,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bds_pkg::PIX_W-1:0]   out_pixel,
  output logic                        row_end,
  output logic                        frame_end
);
  import bds_pkg::*;

  logic              blk_valid;
  logic [PAIR_W-1:0] blk_pair;
  logic              blk_row_end;
  logic              blk_frame_end;
  logic              blk_go;
  logic              accept;
  logic              emit;

  // The block stage moves on whenever the output register is free or being taken
  assign blk_go   = !out_valid || out_ready;
  assign in_ready = !blk_valid || blk_go;
  assign accept   = in_valid && in_ready;
  assign emit     = step.keep && step.odd_col && step.odd_row;

  // Block stage: bottom pair sums wait here for the line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (accept) begin
      blk_valid <= emit;
    end else if (blk_go) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      blk_pair      <= pair;
      blk_row_end   <= step.row_end;
      blk_frame_end <= step.frame_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (blk_go) begin
      out_valid <= blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_go && blk_valid) begin
      out_pixel <= block_mean(top_pair, blk_pair);
      row_end   <= blk_row_end;
      frame_end <= blk_frame_end;
    end
  end

  a_stall_holds_block: assert property (@(posedge clk) disable iff (rst)
    blk_valid && out_valid && !out_ready |=> blk_valid)
    else $error("block lost while output stalled");
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> blk_valid && out_valid && !out_ready)
    else $error("input refused with room in the pipe");
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

endmodule

// ===== design/box_downsample_2x2_rgba.sv =====
// Top level of the 2x2 box-filter downsampler for 32-bit four-channel pixels.
// Depends on bds_pkg, bds_ctrl, bds_line and bds_out.
//
// Source pixels enter on in_pixel with in_valid/in_ready in raster order; each
// 2x2 block gives one output pixel on out_pixel with out_valid/out_ready, each
// byte the floor mean of its four source bytes. row_end and frame_end mark the
// last pixel of an output row and of the frame. An odd last column or row is
// taken in and dropped.
// src_width (index 0) and src_height (index 1) are written through cfg_write,
// cfg_index and cfg_data while the block is idle; a write restarts the frame.
// Throughput is one source pixel per cycle while in_ready is high. The request
// that completes a block passes through the block stage, which covers the
// registered line store read, and then through the output register.
// When out_ready is low the output register holds and one more block is kept in
// the block stage; in_ready falls only when both are full, requests that make no
// result still pass while a result waits.
// Reset sets the sizes to 640 x 480, clears the counters and empties the pipe;
// the line store is not cleared, each odd row reads what the row above wrote.
module box_downsample_2x2_rgba #(
  parameter int MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bds_pkg::DIM_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bds_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bds_pkg::PIX_W-1:0]      out_pixel,
  output logic                           row_end,
  output logic                           frame_end
);
  import bds_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  step_t             step;
  logic [XW-1:0]     col;
  logic [PAIR_W-1:0] pair;
  logic [PAIR_W-1:0] top_pair;
  logic              accept;

  assign accept = in_valid && in_ready;

  bds_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .step      (step),
    .col       (col)
  );

  bds_line #(.MAX_WIDTH(MAX_WIDTH)) u_line (
    .clk      (clk),
    .accept   (accept),
    .in_pixel (in_pixel),
    .step     (step),
    .col      (col),
    .pair     (pair),
    .top_pair (top_pair)
  );

  bds_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .step      (step),
    .pair      (pair),
    .top_pair  (top_pair),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

endmodule
